/* rtl/tpr_pkg.sv */
// Shared constants and types for the tile-map pixel renderer.
// Store geometry, register and transaction codes, alpha values.
// No dependencies.
package tpr_pkg;

  localparam int MAP_AW          = 12;
  localparam int MAP_ENTRIES     = 1 << MAP_AW;
  localparam int TILE_AW         = 10;
  localparam int TILE_COUNT      = 1 << TILE_AW;
  localparam int TILE_SIDE_LOG2  = 3;
  localparam int TILE_SIDE       = 1 << TILE_SIDE_LOG2;
  localparam int TILESET_AW      = TILE_AW + 2 * TILE_SIDE_LOG2;
  localparam int TILESET_DEPTH   = TILE_COUNT * TILE_SIDE * TILE_SIDE;
  localparam int PAL_AW          = 8;
  localparam int PAL_ENTRIES     = 1 << PAL_AW;

  localparam int COORD_W         = 10;
  localparam int CELL_W          = COORD_W - TILE_SIDE_LOG2;
  localparam int INDEX_W         = 16;
  localparam int WORD_W          = 16;
  localparam int CIDX_W          = 8;
  localparam int CHAN_W          = 8;
  localparam int COMP_W          = 5;
  localparam int CFG_DATA_W      = 10;

  localparam logic [COORD_W-1:0] MAP_SIZE_RESET    = COORD_W'(512);
  localparam logic [CHAN_W-1:0]  ALPHA_TRANSLUCENT = CHAN_W'(159);
  localparam logic [CHAN_W-1:0]  ALPHA_OPAQUE      = CHAN_W'(255);

  typedef enum logic [1:0] {
    MODE_MAP   = 2'd0,
    MODE_TILE  = 2'd1,
    MODE_PAL   = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_MAP_WIDTH   = 2'd0,
    CFG_MAP_HEIGHT  = 2'd1,
    CFG_TRANSLUCENT = 2'd2
  } cfg_index_t;

endpackage

/* rtl/tpr_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Read data holds while the read enable is low; a same-address read returns the old word.
// No dependencies.
module tpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

/* rtl/tilemap_pixel_renderer.sv */
// Tile-map pixel renderer top level: three-stage memory pipeline over map, tileset, palette.
// Depends on tpr_pkg and tpr_ram.
//
// One transaction is accepted per clock while in_ready is high. A pixel query's result is
// presented once it has passed through the chain of three dependent memory reads (tile map,
// then tileset, then palette), each of which registers its data for the next.
// Writes go through the same pipeline and update each store at the stage where that store
// is read, so every query sees exactly the writes accepted before it.
// Writes give no result. The stores (4096 x 16 map, 65536 x 8 tileset, 256 x 16 palette)
// are not cleared by reset. Each stage holds when the one after it is full, so a waiting
// result stalls only as much of the pipeline as is full behind it.
module tilemap_pixel_renderer
  import tpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            mode,
  input  logic [INDEX_W-1:0]    write_address,
  input  logic [WORD_W-1:0]     write_data,
  input  logic [COORD_W-1:0]    pixel_x,
  input  logic [COORD_W-1:0]    pixel_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAN_W-1:0]     red,
  output logic [CHAN_W-1:0]     green,
  output logic [CHAN_W-1:0]     blue,
  output logic [CHAN_W-1:0]     alpha
);

  logic [COORD_W-1:0] map_width;
  logic [COORD_W-1:0] map_height;
  logic               translucent;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width   <= MAP_SIZE_RESET;
      map_height  <= MAP_SIZE_RESET;
      translucent <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MAP_WIDTH:   map_width   <= cfg_data;
        CFG_MAP_HEIGHT:  map_height  <= cfg_data;
        CFG_TRANSLUCENT: translucent <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic v1, v2, v3;
  logic mv1, mv2, mv3, accept;
  mode_t s1_mode, s2_mode, s3_mode;

  assign mv3      = v3 && (s3_mode != MODE_QUERY || out_ready);
  assign mv2      = v2 && (!v3 || mv3);
  assign mv1      = v1 && (!v2 || mv2);
  assign in_ready = !v1 || mv1;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept || (v1 && !mv1);
      v2 <= mv1 || (v2 && !mv2);
      v3 <= mv2 || (v3 && !mv3);
    end
  end

  // stage 0: map address
  logic [CELL_W-1:0]  pitch, cell_x, cell_y;
  logic [INDEX_W-1:0] map_sum;
  logic               outside;

  assign pitch   = map_width[COORD_W-1:TILE_SIDE_LOG2];
  assign cell_x  = pixel_x[COORD_W-1:TILE_SIDE_LOG2];
  assign cell_y  = pixel_y[COORD_W-1:TILE_SIDE_LOG2];
  assign map_sum = INDEX_W'(pitch) * INDEX_W'(cell_y) + INDEX_W'(cell_x);
  assign outside = (pixel_x >= map_width) || (pixel_y >= map_height);

  logic [WORD_W-1:0] map_rdata;

  tpr_ram #(.WIDTH(WORD_W), .DEPTH(MAP_ENTRIES)) u_map_ram (
    .clk   (clk),
    .we    (accept && mode_t'(mode) == MODE_MAP),
    .waddr (MAP_AW'(write_address)),
    .wdata (write_data),
    .re    (accept),
    .raddr (MAP_AW'(map_sum)),
    .rdata (map_rdata)
  );

  logic [INDEX_W-1:0]        s1_addr;
  logic [WORD_W-1:0]         s1_data;
  logic                      s1_outside;
  logic [TILE_SIDE_LOG2-1:0] s1_sub_x, s1_sub_y;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode    <= mode_t'(mode);
      s1_addr    <= write_address;
      s1_data    <= write_data;
      s1_outside <= outside;
      s1_sub_x   <= pixel_x[TILE_SIDE_LOG2-1:0];
      s1_sub_y   <= pixel_y[TILE_SIDE_LOG2-1:0];
    end
  end

  // stage 1: tileset lookup
  logic [TILESET_AW-1:0] pix_index;
  logic [CIDX_W-1:0]     tile_rdata;

  assign pix_index = {map_rdata[TILE_AW-1:0], s1_sub_y, s1_sub_x};

  tpr_ram #(.WIDTH(CIDX_W), .DEPTH(TILESET_DEPTH)) u_tile_ram (
    .clk   (clk),
    .we    (mv1 && s1_mode == MODE_TILE),
    .waddr (TILESET_AW'(s1_addr)),
    .wdata (s1_data[CIDX_W-1:0]),
    .re    (mv1),
    .raddr (pix_index),
    .rdata (tile_rdata)
  );

  logic [INDEX_W-1:0] s2_addr;
  logic [WORD_W-1:0]  s2_data;
  logic               s2_outside;

  always_ff @(posedge clk) begin
    if (mv1) begin
      s2_mode    <= s1_mode;
      s2_addr    <= s1_addr;
      s2_data    <= s1_data;
      s2_outside <= s1_outside;
    end
  end

  // stage 2: palette lookup
  logic [WORD_W-1:0] pal_rdata;

  tpr_ram #(.WIDTH(WORD_W), .DEPTH(PAL_ENTRIES)) u_pal_ram (
    .clk   (clk),
    .we    (mv2 && s2_mode == MODE_PAL),
    .waddr (s2_addr[PAL_AW-1:0]),
    .wdata (s2_data),
    .re    (mv2),
    .raddr (tile_rdata[PAL_AW-1:0]),
    .rdata (pal_rdata)
  );

  logic s3_blank;

  always_ff @(posedge clk) begin
    if (mv2) begin
      s3_mode  <= s2_mode;
      s3_blank <= s2_outside || (tile_rdata == '0);
    end
  end

  // stage 3: colour expansion
  assign out_valid = v3 && s3_mode == MODE_QUERY;
  assign red   = s3_blank ? '0 : {pal_rdata[COMP_W-1:0], (CHAN_W-COMP_W)'(0)};
  assign green = s3_blank ? '0 : {pal_rdata[2*COMP_W-1:COMP_W], (CHAN_W-COMP_W)'(0)};
  assign blue  = s3_blank ? '0 : {pal_rdata[3*COMP_W-1:2*COMP_W], (CHAN_W-COMP_W)'(0)};
  assign alpha = s3_blank ? '0 : (translucent ? ALPHA_TRANSLUCENT : ALPHA_OPAQUE);

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> v1 && v2 && v3)
    else $error("input blocked with a free pipeline stage");

  a_writes_never_stall: assert property (@(posedge clk) disable iff (rst)
    v3 && s3_mode != MODE_QUERY |-> mv3)
    else $error("write transaction stalled at the tail");

  a_pal_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !mv3 |=> v3 && (pal_rdata === $past(pal_rdata)))
    else $error("palette data changed under a stalled result");

  a_tile_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !mv2 |=> v2 && (tile_rdata === $past(tile_rdata)))
    else $error("tileset data changed under a stalled stage");

endmodule
